/* rtl/core/seek_flee_arrive_steering_assert.svh */
// ----------------------------------------------------------------------------
// seek_flee_arrive_steering assertion macros
// shared concurrent property forms for the steering core
// ----------------------------------------------------------------------------
`ifndef SEEK_FLEE_ARRIVE_STEERING_ASSERT_SVH
`define SEEK_FLEE_ARRIVE_STEERING_ASSERT_SVH

// same-cycle implication
`define SFAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering core assertion failed");

// next-cycle implication
`define SFAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering core assertion failed");

`endif

/* rtl/core/sfas_pkg.sv */
// ----------------------------------------------------------------------------
// sfas_pkg
// types, codes and helpers shared by the steering core
// ----------------------------------------------------------------------------
package sfas_pkg;

  localparam int CFG_W = 31;

  localparam logic [2:0] ACT_SEEK   = 3'd0;
  localparam logic [2:0] ACT_FLEE   = 3'd1;
  localparam logic [2:0] ACT_ARRIVE = 3'd2;
  localparam logic [2:0] ACT_PURSUE = 3'd3;
  localparam logic [2:0] ACT_EVADE  = 3'd4;

  localparam logic [2:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [2:0] REG_MAX_ACCEL      = 3'd1;
  localparam logic [2:0] REG_PANIC_DISTANCE = 3'd2;
  localparam logic [2:0] REG_SLOW_RADIUS    = 3'd3;
  localparam logic [2:0] REG_STOP_RADIUS    = 3'd4;
  localparam logic [2:0] REG_MAX_PREDICTION = 3'd5;

  localparam logic [63:0] SPEED_EPS = 64'd66;

  typedef enum logic [2:0] {
    CLS_SEEK,
    CLS_FLEE,
    CLS_ARRIVE,
    CLS_PURSUE,
    CLS_EVADE,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] max_accel;
    logic [CFG_W-1:0] panic_distance;
    logic [CFG_W-1:0] slow_radius;
    logic [CFG_W-1:0] stop_radius;
    logic [CFG_W-1:0] max_prediction;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [39:0] mag40(input logic signed [39:0] v);
    logic [39:0] r;
    r = v[39] ? 40'(-v) : 40'(v);
    return r;
  endfunction

  function automatic logic [32:0] mag32(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = {v[31], v};
    return w[32] ? 33'(-w) : 33'(w);
  endfunction

endpackage

/* rtl/core/sfas_front.sv */
// ----------------------------------------------------------------------------
// sfas_front
// accepts a transaction, decodes the action and forms the target offset
// ----------------------------------------------------------------------------
module sfas_front (
  input  logic                start,
  input  logic                full,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_vel_x,
  input  logic signed [31:0]  in_vel_y,
  input  logic signed [31:0]  in_target_x,
  input  logic signed [31:0]  in_target_y,
  input  logic signed [31:0]  in_target_vel_x,
  input  logic signed [31:0]  in_target_vel_y,
  output logic                push,
  output sfas_pkg::item_t     item
);

  sfas_pkg::cls_t     cls;
  logic signed [32:0] to_x;
  logic signed [32:0] to_y;

  assign push = start && !full;
  assign to_x = {in_target_x[31], in_target_x} - {in_pos_x[31], in_pos_x};
  assign to_y = {in_target_y[31], in_target_y} - {in_pos_y[31], in_pos_y};

  always_comb begin
    unique case (in_action)
      sfas_pkg::ACT_SEEK:   cls = sfas_pkg::CLS_SEEK;
      sfas_pkg::ACT_FLEE:   cls = sfas_pkg::CLS_FLEE;
      sfas_pkg::ACT_ARRIVE: cls = sfas_pkg::CLS_ARRIVE;
      sfas_pkg::ACT_PURSUE: cls = sfas_pkg::CLS_PURSUE;
      sfas_pkg::ACT_EVADE:  cls = sfas_pkg::CLS_EVADE;
      default:              cls = sfas_pkg::CLS_NONE;
    endcase
  end

  always_comb begin
    item.cls = cls;
    // flee heads away from the target
    item.ex  = (cls == sfas_pkg::CLS_FLEE) ? 33'(-to_x) : to_x;
    item.ey  = (cls == sfas_pkg::CLS_FLEE) ? 33'(-to_y) : to_y;
    item.vx  = in_vel_x;
    item.vy  = in_vel_y;
    item.px  = in_pos_x;
    item.py  = in_pos_y;
    item.tx  = in_target_x;
    item.ty  = in_target_y;
    item.tvx = in_target_vel_x;
    item.tvy = in_target_vel_y;
  end

endmodule

/* rtl/core/sfas_fifo.sv */
// ----------------------------------------------------------------------------
// sfas_fifo
// short queue of decoded transactions between front and back
// ----------------------------------------------------------------------------
`include "seek_flee_arrive_steering_assert.svh"

module sfas_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfas_pkg::item_t wr_item,
  input  logic            pop,
  output sfas_pkg::item_t rd_item,
  output logic            full,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfas_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  `SFAS_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push)
  `SFAS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, empty, !pop)
  `SFAS_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CW'(1))

endmodule

/* rtl/core/sfas_vlen.sv */
// ----------------------------------------------------------------------------
// sfas_vlen
// vector length: prescale, squares, then one root bit per cycle
// ----------------------------------------------------------------------------
module sfas_vlen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] x,
  input  logic signed [39:0] y,
  output logic               done,
  output logic [63:0]        len
);

  typedef enum logic [1:0] {V_IDLE, V_SQ, V_SUM, V_RUN} vstate_t;

  vstate_t     state_r;
  logic [30:0] axs_r;
  logic [30:0] ays_r;
  logic [3:0]  sh_r;
  logic [61:0] sqx_r;
  logic [61:0] sqy_r;
  logic [63:0] rad_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [63:0] len_r;

  logic [39:0] ax;
  logic [39:0] ay;
  logic [39:0] orv;
  logic [5:0]  msb;
  logic [3:0]  sh;
  logic [39:0] axs;
  logic [39:0] ays;
  logic [35:0] remn;
  logic [35:0] trial;
  logic        take;
  logic [31:0] root_n;

  always_comb begin
    ax  = sfas_pkg::mag40(x);
    ay  = sfas_pkg::mag40(y);
    orv = ax | ay;
    msb = '0;
    for (int i = 0; i < 40; i++) begin
      if (orv[i]) msb = 6'(i);
    end
    sh  = (msb > 6'd30) ? 4'(msb - 6'd30) : 4'd0;
    axs = ax >> sh;
    ays = ay >> sh;
  end

  assign remn   = {rem_r[33:0], rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = (remn >= trial);
  assign root_n = {root_r[30:0], take};
  assign done   = done_r;
  assign len    = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        V_IDLE: begin
          if (start) begin
            axs_r   <= axs[30:0];
            ays_r   <= ays[30:0];
            sh_r    <= sh;
            state_r <= V_SQ;
          end
        end
        V_SQ: begin
          sqx_r   <= 62'(axs_r) * 62'(axs_r);
          sqy_r   <= 62'(ays_r) * 62'(ays_r);
          state_r <= V_SUM;
        end
        V_SUM: begin
          rad_r   <= 64'(sqx_r) + 64'(sqy_r);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 5'd31;
          state_r <= V_RUN;
        end
        V_RUN: begin
          rem_r  <= take ? 35'(remn - trial) : remn[34:0];
          root_r <= root_n;
          rad_r  <= {rad_r[61:0], 2'b00};
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            len_r   <= {32'd0, root_n} << sh_r;
            done_r  <= 1'b1;
            state_r <= V_IDLE;
          end
        end
        default: state_r <= V_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/sfas_div.sv */
// ----------------------------------------------------------------------------
// sfas_div
// unsigned 64 by 64 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sfas_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t     state_r;
  logic [63:0] n_r;
  logic [63:0] den_r;
  logic [63:0] rem_r;
  logic [5:0]  cnt_r;
  logic        done_r;

  logic [64:0] rs;
  logic        qbit;

  assign rs   = {rem_r, n_r[63]};
  assign qbit = (rs >= {1'b0, den_r});
  assign done = done_r;
  assign quo  = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            n_r     <= num;
            den_r   <= den;
            rem_r   <= '0;
            cnt_r   <= 6'd63;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= qbit ? 64'(rs - {1'b0, den_r}) : rs[63:0];
          n_r   <= {n_r[62:0], qbit};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/sfas_back.sv */
// ----------------------------------------------------------------------------
// sfas_back
// sequencer that carries out one queued transaction on shared units
// ----------------------------------------------------------------------------
`include "seek_flee_arrive_steering_assert.svh"

module sfas_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  sfas_pkg::item_t    head,
  input  sfas_pkg::cfg_t     cfg,
  output logic               pop,
  output logic               out_valid,
  output logic signed [31:0] out_steer_x,
  output logic signed [31:0] out_steer_y
);

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_GO, S_LEN_WAIT, S_TS_MUL, S_TS_GO, S_TS_WAIT, S_PD_GO, S_PD_WAIT,
    S_PMX, S_PAX, S_PAY, S_SC_MX, S_SC_GX, S_SC_WX, S_SC_MY, S_SC_GY, S_SC_WY,
    S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_FLEE, PH_SEEK, PH_ARRIVE, PH_DIST, PH_SPEED, PH_FIN
  } phase_t;

  state_t             state_r;
  phase_t             phase_r;
  logic               fin_r;
  logic               evade_r;
  logic signed [39:0] ex_r;
  logic signed [39:0] ey_r;
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [31:0] tx_r;
  logic signed [31:0] ty_r;
  logic signed [31:0] tvx_r;
  logic signed [31:0] tvy_r;
  logic signed [31:0] fx_r;
  logic [63:0]        d_r;
  logic [63:0]        den_r;
  logic [30:0]        num_r;
  logic [30:0]        pred_r;
  logic [63:0]        prod_r;
  logic               out_valid_r;
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;

  logic [39:0]        mul_a;
  logic [30:0]        mul_b;
  logic [70:0]        mul_p;
  logic               vl_start;
  logic signed [39:0] vl_x;
  logic signed [39:0] vl_y;
  logic               vl_done;
  logic [63:0]        vl_len;
  logic               dv_start;
  logic [63:0]        dv_num;
  logic [63:0]        dv_den;
  logic               dv_done;
  logic [63:0]        dv_quo;
  logic signed [39:0] q_x;
  logic signed [39:0] q_y;
  logic signed [31:0] fy;

  function automatic logic signed [31:0] pred_pos(input logic signed [31:0] t,
                                                  input logic neg,
                                                  input logic [63:0] prod);
    logic signed [63:0] tt;
    logic signed [63:0] off;
    tt  = 64'(t);
    off = {16'd0, prod[63:16]};
    return sfas_pkg::sat32(neg ? tt - off : tt + off);
  endfunction

  assign pop      = (state_r == S_IDLE) && !empty;
  assign vl_start = (state_r == S_LEN_GO);
  assign vl_x     = (phase_r == PH_SPEED) ? 40'(vx_r) : ex_r;
  assign vl_y     = (phase_r == PH_SPEED) ? 40'(vy_r) : ey_r;
  assign dv_start = (state_r == S_TS_GO) || (state_r == S_PD_GO) ||
                    (state_r == S_SC_GX) || (state_r == S_SC_GY);
  assign mul_p    = 71'(mul_a) * 71'(mul_b);
  assign q_x      = ex_r[39] ? -$signed(dv_quo[39:0]) : $signed(dv_quo[39:0]);
  assign q_y      = ey_r[39] ? -$signed(dv_quo[39:0]) : $signed(dv_quo[39:0]);
  assign fy       = pred_pos(ty_r, tvy_r[31], prod_r);

  always_comb begin
    case (state_r)
      S_TS_MUL: begin
        mul_a = d_r[39:0];
        mul_b = cfg.max_speed;
      end
      S_SC_MX: begin
        mul_a = sfas_pkg::mag40(ex_r);
        mul_b = num_r;
      end
      S_SC_MY: begin
        mul_a = sfas_pkg::mag40(ey_r);
        mul_b = num_r;
      end
      S_PMX: begin
        mul_a = 40'(sfas_pkg::mag32(tvx_r));
        mul_b = pred_r;
      end
      S_PAX: begin
        mul_a = 40'(sfas_pkg::mag32(tvy_r));
        mul_b = pred_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      S_TS_GO: begin
        dv_num = prod_r;
        dv_den = 64'(cfg.slow_radius);
      end
      S_PD_GO: begin
        dv_num = {d_r[47:0], 16'd0};
        dv_den = den_r;
      end
      default: begin
        dv_num = prod_r;
        dv_den = den_r;
      end
    endcase
  end

  sfas_vlen u_vlen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vl_start),
    .x     (vl_x),
    .y     (vl_y),
    .done  (vl_done),
    .len   (vl_len)
  );

  sfas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!empty) begin
            ex_r    <= 40'(head.ex);
            ey_r    <= 40'(head.ey);
            vx_r    <= head.vx;
            vy_r    <= head.vy;
            px_r    <= head.px;
            py_r    <= head.py;
            tx_r    <= head.tx;
            ty_r    <= head.ty;
            tvx_r   <= head.tvx;
            tvy_r   <= head.tvy;
            fin_r   <= 1'b0;
            evade_r <= (head.cls == sfas_pkg::CLS_EVADE);
            state_r <= S_LEN_GO;
            case (head.cls)
              sfas_pkg::CLS_SEEK:   phase_r <= PH_SEEK;
              sfas_pkg::CLS_FLEE:   phase_r <= PH_FLEE;
              sfas_pkg::CLS_ARRIVE: phase_r <= PH_ARRIVE;
              sfas_pkg::CLS_PURSUE,
              sfas_pkg::CLS_EVADE:  phase_r <= PH_DIST;
              default: begin
                ex_r    <= '0;
                ey_r    <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_LEN_GO: state_r <= S_LEN_WAIT;
        S_LEN_WAIT: begin
          if (vl_done) begin
            case (phase_r)
              PH_FLEE, PH_SEEK: begin
                d_r <= vl_len;
                if (phase_r == PH_FLEE && vl_len > 64'(cfg.panic_distance)) begin
                  ex_r    <= '0;
                  ey_r    <= '0;
                  state_r <= S_OUT;
                end else if (vl_len == '0) begin
                  state_r <= S_FIN;
                end else begin
                  num_r   <= cfg.max_speed;
                  den_r   <= vl_len;
                  state_r <= S_SC_MX;
                end
              end
              PH_ARRIVE: begin
                d_r <= vl_len;
                if (vl_len < 64'(cfg.stop_radius) || vl_len == '0) begin
                  // brake: steer against own velocity, no clamp
                  ex_r    <= -40'(vx_r);
                  ey_r    <= -40'(vy_r);
                  state_r <= S_OUT;
                end else if (vl_len < 64'(cfg.slow_radius)) begin
                  state_r <= S_TS_MUL;
                end else begin
                  num_r   <= cfg.max_speed;
                  den_r   <= vl_len;
                  state_r <= S_SC_MX;
                end
              end
              PH_DIST: begin
                d_r     <= vl_len;
                phase_r <= PH_SPEED;
                state_r <= S_LEN_GO;
              end
              PH_SPEED: begin
                den_r <= vl_len;
                if (vl_len > sfas_pkg::SPEED_EPS) begin
                  state_r <= S_PD_GO;
                end else begin
                  pred_r  <= cfg.max_prediction;
                  state_r <= S_PMX;
                end
              end
              default: begin
                if (vl_len > 64'(cfg.max_accel)) begin
                  num_r   <= cfg.max_accel;
                  den_r   <= vl_len;
                  state_r <= S_SC_MX;
                end else begin
                  state_r <= S_OUT;
                end
              end
            endcase
          end
        end
        S_TS_MUL: begin
          prod_r  <= mul_p[63:0];
          state_r <= S_TS_GO;
        end
        S_TS_GO: state_r <= S_TS_WAIT;
        S_TS_WAIT: begin
          if (dv_done) begin
            num_r   <= dv_quo[30:0];
            den_r   <= d_r;
            state_r <= S_SC_MX;
          end
        end
        S_PD_GO: state_r <= S_PD_WAIT;
        S_PD_WAIT: begin
          if (dv_done) begin
            pred_r  <= (dv_quo < 64'(cfg.max_prediction)) ? dv_quo[30:0]
                                                          : cfg.max_prediction;
            state_r <= S_PMX;
          end
        end
        S_PMX: begin
          prod_r  <= mul_p[63:0];
          state_r <= S_PAX;
        end
        S_PAX: begin
          fx_r    <= pred_pos(tx_r, tvx_r[31], prod_r);
          prod_r  <= mul_p[63:0];
          state_r <= S_PAY;
        end
        S_PAY: begin
          ex_r    <= evade_r ? 40'(px_r) - 40'(fx_r) : 40'(fx_r) - 40'(px_r);
          ey_r    <= evade_r ? 40'(py_r) - 40'(fy) : 40'(fy) - 40'(py_r);
          phase_r <= PH_SEEK;
          state_r <= S_LEN_GO;
        end
        S_SC_MX: begin
          prod_r  <= mul_p[63:0];
          state_r <= S_SC_GX;
        end
        S_SC_GX: state_r <= S_SC_WX;
        S_SC_WX: begin
          if (dv_done) begin
            ex_r    <= q_x;
            state_r <= S_SC_MY;
          end
        end
        S_SC_MY: begin
          prod_r  <= mul_p[63:0];
          state_r <= S_SC_GY;
        end
        S_SC_GY: state_r <= S_SC_WY;
        S_SC_WY: begin
          if (dv_done) begin
            ey_r    <= q_y;
            state_r <= fin_r ? S_OUT : S_FIN;
          end
        end
        S_FIN: begin
          ex_r    <= ex_r - 40'(vx_r);
          ey_r    <= ey_r - 40'(vy_r);
          fin_r   <= 1'b1;
          phase_r <= PH_FIN;
          state_r <= S_LEN_GO;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          sx_r        <= sfas_pkg::sat32(64'(ex_r));
          sy_r        <= sfas_pkg::sat32(64'(ey_r));
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_steer_x = sx_r;
  assign out_steer_y = sy_r;

  `SFAS_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `SFAS_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, !out_valid_r || state_r == S_IDLE)

endmodule

/* rtl/core/seek_flee_arrive_steering.sv */
// out_valid follows each accepted transaction once the back has carried it out
// the steps are set by the action: which vector lengths and divides it runs
// the back carries out one transaction at a time; the queue takes Q_DEPTH more
// start is taken whenever busy is low; busy is high only while the queue is full
// reset: synchronous rst_n clears the queue, sequencer and loads config defaults
// ----------------------------------------------------------------------------
// seek_flee_arrive_steering
// steering core for seek, flee, arrive, pursue and evade in Q16.16
// ----------------------------------------------------------------------------
module seek_flee_arrive_steering #(
  parameter int Q_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_vel_x,
  input  logic signed [31:0] in_target_vel_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_steer_x,
  output logic signed [31:0] out_steer_y
);

  sfas_pkg::cfg_t  cfg_r;
  sfas_pkg::item_t wr_item;
  sfas_pkg::item_t rd_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  assign busy = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed      <= 31'd65536;
      cfg_r.max_accel      <= 31'd65536;
      cfg_r.panic_distance <= 31'h7fffffff;
      cfg_r.slow_radius    <= 31'd655360;
      cfg_r.stop_radius    <= 31'd65536;
      cfg_r.max_prediction <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfas_pkg::REG_MAX_SPEED:      cfg_r.max_speed      <= cfg_wdata;
        sfas_pkg::REG_MAX_ACCEL:      cfg_r.max_accel      <= cfg_wdata;
        sfas_pkg::REG_PANIC_DISTANCE: cfg_r.panic_distance <= cfg_wdata;
        sfas_pkg::REG_SLOW_RADIUS:    cfg_r.slow_radius    <= cfg_wdata;
        sfas_pkg::REG_STOP_RADIUS:    cfg_r.stop_radius    <= cfg_wdata;
        sfas_pkg::REG_MAX_PREDICTION: cfg_r.max_prediction <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sfas_front u_front (
    .start           (start),
    .full            (full),
    .in_action       (in_action),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_target_x     (in_target_x),
    .in_target_y     (in_target_y),
    .in_target_vel_x (in_target_vel_x),
    .in_target_vel_y (in_target_vel_y),
    .push            (push),
    .item            (wr_item)
  );

  sfas_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .full    (full),
    .empty   (empty)
  );

  sfas_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .head        (rd_item),
    .cfg         (cfg_r),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_steer_x (out_steer_x),
    .out_steer_y (out_steer_y)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// steering core testbench
// sends seek, flee, arrive, pursue, evade and reserved-action transactions
// under several register settings, predicts each steering vector in Q16.16
// and checks every result in order against the prediction
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] ACT_RSVD_LAST = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 500;
  localparam logic [30:0] REG_MAX = 31'h7fffffff;

  typedef bit [63:0] u64_t;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] px, py, vx, vy, tx, ty, tvx, tvy;
  } steer_req_t;

  typedef struct {
    logic signed [31:0] sx, sy;
  } steer_vec_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_action;
  logic signed [31:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic signed [31:0] in_target_x, in_target_y, in_target_vel_x, in_target_vel_y;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_wdata;
  logic               out_valid;
  logic signed [31:0] out_steer_x, out_steer_y;

  u64_t speed_lim, accel_lim, panic_dist, slow_rad, stop_rad, pred_lim;
  steer_vec_t steer_expected[$];
  int fail_count = 0;
  int sender_idle_pct = 0;
  int idle_cycles = 0;

  seek_flee_arrive_steering uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_target_vel_x(in_target_vel_x), .in_target_vel_y(in_target_vel_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_steer_x(out_steer_x), .out_steer_y(out_steer_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // steering arithmetic
  function automatic u64_t magn(longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t isqrt(u64_t x);
    u64_t res, b;
    res = 0;
    b = u64_t'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic u64_t vec_len(longint x, longint y);
    u64_t ax, ay;
    int s;
    ax = magn(x);
    ay = magn(y);
    s = 0;
    while ((ax >> s) >= 64'h80000000 || (ay >> s) >= 64'h80000000) s++;
    ax >>= s;
    ay >>= s;
    return isqrt(ax * ax + ay * ay) << s;
  endfunction

  function automatic longint scale_by(longint v, u64_t num, u64_t den);
    u64_t m;
    m = magn(v) * num / den;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic steer_vec_t limit_accel(longint dx, longint dy, longint vx, longint vy);
    steer_vec_t r;
    longint sx, sy;
    u64_t m;
    sx = dx - vx;
    sy = dy - vy;
    m = vec_len(sx, sy);
    if (m > accel_lim) begin
      sx = scale_by(sx, accel_lim, m);
      sy = scale_by(sy, accel_lim, m);
    end
    r.sx = clip32(sx);
    r.sy = clip32(sy);
    return r;
  endfunction

  function automatic steer_vec_t steer_toward(longint dx, longint dy, longint vx, longint vy);
    u64_t d;
    d = vec_len(dx, dy);
    if (d > 0) begin
      dx = scale_by(dx, speed_lim, d);
      dy = scale_by(dy, speed_lim, d);
    end
    return limit_accel(dx, dy, vx, vy);
  endfunction

  function automatic longint lead_point(longint t, longint tv, u64_t horizon);
    u64_t m;
    m = (magn(tv) * horizon) >> 16;
    return clip32(t + (tv < 0 ? -longint'(m) : longint'(m)));
  endfunction

  function automatic steer_vec_t predict_steering(steer_req_t q);
    steer_vec_t r;
    longint px, py, vx, vy, tx, ty, fx, fy;
    u64_t d, ts, sp, horizon, p;
    px = q.px; py = q.py; vx = q.vx; vy = q.vy; tx = q.tx; ty = q.ty;
    r.sx = '0;
    r.sy = '0;
    case (q.act)
      sfas_pkg::ACT_SEEK: r = steer_toward(tx - px, ty - py, vx, vy);
      sfas_pkg::ACT_FLEE:
        if (vec_len(px - tx, py - ty) <= panic_dist)
          r = steer_toward(px - tx, py - ty, vx, vy);
      sfas_pkg::ACT_ARRIVE: begin
        d = vec_len(tx - px, ty - py);
        ts = speed_lim;
        if (d < stop_rad || d == 0) begin
          r.sx = clip32(-vx);
          r.sy = clip32(-vy);
        end else begin
          if (d < slow_rad) ts = speed_lim * d / slow_rad;
          r = limit_accel(scale_by(tx - px, ts, d), scale_by(ty - py, ts, d), vx, vy);
        end
      end
      sfas_pkg::ACT_PURSUE, sfas_pkg::ACT_EVADE: begin
        d = vec_len(tx - px, ty - py);
        sp = vec_len(vx, vy);
        horizon = pred_lim;
        if (sp > sfas_pkg::SPEED_EPS) begin
          p = (d << 16) / sp;
          if (p < horizon) horizon = p;
        end
        fx = lead_point(tx, longint'(q.tvx), horizon);
        fy = lead_point(ty, longint'(q.tvy), horizon);
        if (q.act == sfas_pkg::ACT_PURSUE) r = steer_toward(fx - px, fy - py, vx, vy);
        else r = steer_toward(px - fx, py - fy, vx, vy);
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (steer_expected.size() == 0) begin
        $error("unexpected transaction: steer_x %0d steer_y %0d", out_steer_x, out_steer_y);
        fail_count++;
      end else begin
        if (out_steer_x !== steer_expected[0].sx) begin
          $error("steer_x expected %0d actual %0d", steer_expected[0].sx, out_steer_x);
          fail_count++;
        end
        if (out_steer_y !== steer_expected[0].sy) begin
          $error("steer_y expected %0d actual %0d", steer_expected[0].sy, out_steer_y);
          fail_count++;
        end
        void'(steer_expected.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(steer_req_t q);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= q.act;
    in_pos_x <= q.px; in_pos_y <= q.py;
    in_vel_x <= q.vx; in_vel_y <= q.vy;
    in_target_x <= q.tx; in_target_y <= q.ty;
    in_target_vel_x <= q.tvx; in_target_vel_y <= q.tvy;
    do @(posedge clk); while (busy);
    steer_expected.push_back(predict_steering(q));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (steer_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sfas_pkg::REG_MAX_SPEED:      speed_lim = val;
      sfas_pkg::REG_MAX_ACCEL:      accel_lim = val;
      sfas_pkg::REG_PANIC_DISTANCE: panic_dist = val;
      sfas_pkg::REG_SLOW_RADIUS:    slow_rad = val;
      sfas_pkg::REG_STOP_RADIUS:    stop_rad = val;
      sfas_pkg::REG_MAX_PREDICTION: pred_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [30:0] spd, logic [30:0] acc, logic [30:0] pan,
                         logic [30:0] slw, logic [30:0] stp, logic [30:0] prd);
    write_reg(sfas_pkg::REG_MAX_SPEED, spd);
    write_reg(sfas_pkg::REG_MAX_ACCEL, acc);
    write_reg(sfas_pkg::REG_PANIC_DISTANCE, pan);
    write_reg(sfas_pkg::REG_SLOW_RADIUS, slw);
    write_reg(sfas_pkg::REG_STOP_RADIUS, stp);
    write_reg(sfas_pkg::REG_MAX_PREDICTION, prd);
  endtask

  function automatic steer_req_t make_req(logic [2:0] a, int px, int py, int vx, int vy,
                                          int tx, int ty, int tvx, int tvy);
    steer_req_t q;
    q.act = a; q.px = px; q.py = py; q.vx = vx; q.vy = vy;
    q.tx = tx; q.ty = ty; q.tvx = tvx; q.tvy = tvy;
    return q;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
      default: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
    endcase
  endfunction

  function automatic steer_req_t rand_req();
    steer_req_t q;
    q.act = ($urandom_range(19) == 0) ?
            3'($urandom_range(sfas_pkg::ACT_EVADE + 1, ACT_RSVD_LAST)) :
            3'($urandom_range(sfas_pkg::ACT_SEEK, sfas_pkg::ACT_EVADE));
    q.px = rand_coord(); q.py = rand_coord();
    q.vx = rand_coord(); q.vy = rand_coord();
    q.tvx = rand_coord(); q.tvy = rand_coord();
    if ($urandom_range(2) == 0) begin
      q.tx = rand_coord();
      q.ty = rand_coord();
    end else begin
      q.tx = q.px + ($signed($urandom_range(0, 2 ** 21)) - (2 ** 20));
      q.ty = q.py + ($signed($urandom_range(0, 2 ** 21)) - (2 ** 20));
    end
    if ($urandom_range(9) == 0) begin
      q.vx = $signed($urandom_range(0, 80)) - 40;
      q.vy = $signed($urandom_range(0, 80)) - 40;
    end
    return q;
  endfunction

  task automatic test_directed();
    logic [2:0] a;
    for (int k = 0; k <= int'(ACT_RSVD_LAST); k++) begin
      a = 3'(k);
      send_item(make_req(a, 0, 0, 65536, -65536, 5 * 65536, 3 * 65536, 65536, 65536));
    end
    send_item(make_req(sfas_pkg::ACT_SEEK, 100, 100, 0, 0, 100, 100, 0, 0));
    send_item(make_req(sfas_pkg::ACT_FLEE, 100, 100, 7, 9, 100, 100, 0, 0));
    send_item(make_req(sfas_pkg::ACT_ARRIVE, 0, 0, 300, -200, 0, 0, 0, 0));
    send_item(make_req(sfas_pkg::ACT_ARRIVE, 0, 0, 300, -200, 20000, 0, 0, 0));
    send_item(make_req(sfas_pkg::ACT_ARRIVE, 0, 0, 0, 0, 3 * 65536, 4 * 65536, 0, 0));
    send_item(make_req(sfas_pkg::ACT_ARRIVE, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    send_item(make_req(sfas_pkg::ACT_SEEK, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0));
    send_item(make_req(sfas_pkg::ACT_FLEE, 32'h7fffffff, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0));
    send_item(make_req(sfas_pkg::ACT_PURSUE, 0, 0, 10, 10, 65536, 0,
                       32'h7fffffff, 32'h80000000));
    send_item(make_req(sfas_pkg::ACT_EVADE, 0, 0, 5 * 65536, 0, 65536, 65536,
                       32'h80000000, 32'h7fffffff));
    send_item(make_req(sfas_pkg::ACT_PURSUE, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_item(make_req(sfas_pkg::ACT_EVADE, 0, 0, 66, 0, 65536, 0, 65536, 0));
    drain();
    set_all(31'd65536, 31'd65536, 31'(4 * 65536), 31'(10 * 65536), 31'd65536, 31'd65536);
    send_item(make_req(sfas_pkg::ACT_FLEE, 0, 0, 0, 0, 4 * 65536, 0, 0, 0));
    send_item(make_req(sfas_pkg::ACT_FLEE, 0, 0, 0, 0, 4 * 65536 + 1, 0, 0, 0));
    send_item(make_req(sfas_pkg::ACT_EVADE, 0, 0, 0, 0, 9 * 65536, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    repeat (n) send_item(rand_req());
  endtask

  task automatic test_config_extremes();
    set_all(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    test_random(50);
    set_all('0, '0, '0, '0, '0, '0);
    test_random(50);
    set_all(31'($urandom), 31'($urandom_range(1, 2 ** 22)), 31'($urandom_range(0, 2 ** 22)),
            31'($urandom_range(0, 2 ** 21)), 31'($urandom_range(0, 2 ** 17)),
            31'($urandom_range(0, 2 ** 20)));
    test_random(50);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_action = '0;
    {in_pos_x, in_pos_y, in_vel_x, in_vel_y} = '0;
    {in_target_x, in_target_y, in_target_vel_x, in_target_vel_y} = '0;
    speed_lim = 65536; accel_lim = 65536; panic_dist = 64'h7fffffff;
    slow_rad = 655360; stop_rad = 65536; pred_lim = 65536;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 32;
    test_directed();
    test_random(140);
    sender_idle_pct = 70;
    test_config_extremes();
    sender_idle_pct = 0;
    set_all(31'(2 * 65536), 31'(3 * 65536), 31'd2 ** 21, 31'd2 ** 20, 31'd2 ** 16,
            31'(3 * 65536));
    test_random(140);
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/sfas_pkg.sv
rtl/core/sfas_front.sv
rtl/core/sfas_fifo.sv
rtl/core/sfas_vlen.sv
rtl/core/sfas_div.sv
rtl/core/sfas_back.sv
rtl/core/seek_flee_arrive_steering.sv
tb/testbench.sv
